>>> hdl/mi3_pkg.sv
// Shared types, register indexes and cofactor wiring for the 3x3 matrix inverse.
`timescale 1ns / 1ps
package mi3_pkg;

   localparam int DATA_W     = 32;
   localparam int THR_W      = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int NUM_ENT    = 9;

   localparam logic [CSR_ADDR_W-1:0] CSR_SYMMETRIC = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD = CSR_ADDR_W'(1);

   // Entry order: xx xy xz yx yy yz zx zy zz
   localparam int IX_XX = 0;
   localparam int IX_XY = 1;
   localparam int IX_XZ = 2;
   localparam int IX_YX = 3;
   localparam int IX_YY = 4;
   localparam int IX_YZ = 5;
   localparam int IX_ZX = 6;
   localparam int IX_ZY = 7;
   localparam int IX_ZZ = 8;

   // Adjugate entry i = e[A]*e[B] - e[C]*e[D]
   localparam int COF_A [NUM_ENT] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int COF_B [NUM_ENT] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int COF_C [NUM_ENT] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int COF_D [NUM_ENT] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

   // Results forced to zero in symmetric mode: yx, zx, zy
   localparam logic [NUM_ENT-1:0] SYM_DROP = 9'b011001000;

   typedef logic signed [DATA_W-1:0] ent_type;

   typedef struct packed {
      ent_type m_xx;
      ent_type m_xy;
      ent_type m_xz;
      ent_type m_yx;
      ent_type m_yy;
      ent_type m_yz;
      ent_type m_zx;
      ent_type m_zy;
      ent_type m_zz;
   } req_type;

   typedef struct packed {
      ent_type r_xx;
      ent_type r_xy;
      ent_type r_xz;
      ent_type r_yx;
      ent_type r_yy;
      ent_type r_yz;
      ent_type r_zx;
      ent_type r_zy;
      ent_type r_zz;
      logic    singular;
      logic    saturated;
   } rsp_type;

endpackage

>>> hdl/mi3_cof_lane.sv
// One cofactor lane: two registered products and their registered difference.
`timescale 1ns / 1ps
module mi3_cof_lane import mi3_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  ent_type                 a,
   input  ent_type                 b,
   input  ent_type                 c,
   input  ent_type                 d,
   output logic signed [2*DATA_W:0] cof
);
   localparam int PW = 2 * DATA_W;
   localparam int CW = PW + 1;

   logic signed [PW-1:0] pab_ff;
   logic signed [PW-1:0] pcd_ff;
   logic signed [CW-1:0] cof_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pab_ff <= a * b;
         pcd_ff <= c * d;
         cof_ff <= CW'(pab_ff) - CW'(pcd_ff);
      end
   end

   assign cof = cof_ff;
endmodule

>>> hdl/mi3_det.sv
// Determinant by expansion along row x, its magnitude and the singular test.
`timescale 1ns / 1ps
module mi3_det import mi3_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     en,
   input  ent_type                  ev [3],
   input  logic signed [2*DATA_W:0] cv [3],
   input  logic [THR_W-1:0]         thr,
   output logic [3*DATA_W-1:0]      dabs,
   output logic                     dneg,
   output logic                     sing
);
   localparam int W    = DATA_W;
   localparam int CW   = 2 * W + 1;
   localparam int LO   = W + 1;
   localparam int DW   = 3 * W + 2;
   localparam int MAGW = 3 * W;
   localparam int TSW  = THR_W + 2 * FRAC_BITS;
   localparam int SW   = (MAGW > TSW) ? MAGW : TSW;

   logic signed [2*W-1:0] ph_ff [3];
   logic signed [2*W+1:0] pl_ff [3];
   logic signed [DW-1:0]  t_ff [3];
   logic signed [DW-1:0]  det_ff;
   logic [MAGW-1:0]       dabs_ff;
   logic                  dneg_ff;
   logic                  sing_ff;

   logic [DW-1:0]         dmag;
   logic [MAGW-1:0]       dabs_in;
   logic [SW-1:0]         thr_scaled;

   // Split each cofactor into a signed high half and an unsigned low half
   for (genvar k = 0; k < 3; k++) begin : g_part
      always_ff @(posedge clock) begin
         if (en) begin
            ph_ff[k] <= ev[k] * $signed(cv[k][CW-1:LO]);
            pl_ff[k] <= ev[k] * $signed({1'b0, cv[k][LO-1:0]});
            t_ff[k]  <= (DW'(ph_ff[k]) <<< LO) + DW'(pl_ff[k]);
         end
      end
   end

   assign dmag       = det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
   assign dabs_in    = dmag[MAGW-1:0];
   assign thr_scaled = SW'(thr) << (2 * FRAC_BITS);

   always_ff @(posedge clock) begin
      if (en) begin
         det_ff  <= t_ff[0] + t_ff[1] + t_ff[2];
         dneg_ff <= det_ff[DW-1];
         dabs_ff <= dabs_in;
         sing_ff <= (dabs_in == '0) || (SW'(dabs_in) < thr_scaled);
      end
   end

   assign dabs = dabs_ff;
   assign dneg = dneg_ff;
   assign sing = sing_ff;
endmodule

>>> hdl/mi3_div_lane.sv
// One quotient lane: restoring division one bit a stage, rounding and saturation.
`timescale 1ns / 1ps
module mi3_div_lane import mi3_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [2*DATA_W:0]             cof,
   input  logic                                 dneg,
   input  logic [DATA_W+1:0][3*DATA_W-1:0]      dvec,
   output ent_type                              res,
   output logic                                 sat
);
   localparam int W    = DATA_W;
   localparam int CW   = 2 * W + 1;
   localparam int MAGW = 3 * W;
   localparam int NW   = CW + 2 * FRAC_BITS;
   localparam int SHW  = MAGW + W;
   localparam int CMPW = (NW > SHW) ? NW : SHW;

   logic [CW-1:0]   cmag;
   logic [NW-1:0]   num;
   logic            ovf_in;

   logic [MAGW-1:0] rem_ff [W+1];
   logic [W-1:0]    q_ff   [W+1];
   logic [W-1:0]    nlo_ff [W];
   logic            neg_ff [W+1];
   logic            ovf_ff [W+1];

   logic            up;
   logic [W:0]      qr;
   logic [W:0]      lim;
   logic [W:0]      mag;
   logic [W:0]      sgn_mag;
   logic            sat_in;
   ent_type         res_ff;
   logic            sat_ff;

   assign cmag   = cof[CW-1] ? CW'(-cof) : CW'(cof);
   assign num    = NW'(cmag) << (2 * FRAC_BITS);
   // Quotient needs more than W bits: saturate without dividing
   assign ovf_in = CMPW'(num) >= (CMPW'(dvec[0]) << W);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= MAGW'(num >> W);
         nlo_ff[0] <= num[W-1:0];
         q_ff[0]   <= '0;
         neg_ff[0] <= cof[CW-1] ^ dneg;
         ovf_ff[0] <= ovf_in;
      end
   end

   for (genvar j = 1; j <= W; j++) begin : g_step
      logic [MAGW:0] rem2;
      logic [MAGW:0] diff;
      logic          ge;

      assign rem2 = {rem_ff[j-1], nlo_ff[j-1][W-1]};
      assign diff = rem2 - {1'b0, dvec[j]};
      assign ge   = rem2 >= {1'b0, dvec[j]};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= ge ? diff[MAGW-1:0] : rem2[MAGW-1:0];
            q_ff[j]   <= {q_ff[j-1][W-2:0], ge};
            neg_ff[j] <= neg_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end

      if (j < W) begin : g_nlo
         always_ff @(posedge clock) begin
            if (en) begin
               nlo_ff[j] <= nlo_ff[j-1] << 1;
            end
         end
      end
   end

   // Round to nearest, ties away from zero, then clip to the signed range
   always_comb begin
      up      = {rem_ff[W], 1'b0} >= {1'b0, dvec[W+1]};
      qr      = {1'b0, q_ff[W]} + (W+1)'(up);
      lim     = neg_ff[W] ? {2'b01, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};
      sat_in  = ovf_ff[W] || (qr > lim);
      mag     = sat_in ? lim : qr;
      sgn_mag = neg_ff[W] ? ((W+1)'(0) - mag) : mag;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= sgn_mag[W-1:0];
         sat_ff <= sat_in;
      end
   end

   assign res = res_ff;
   assign sat = sat_ff;
endmodule

>>> hdl/matrix_inverse_3x3.sv
// Top level: 3x3 fixed-point matrix inverse by adjugate, pipelined lanes.
//
//  channel | ports                          | carries
//  --------+--------------------------------+----------------------------------
//  request | req_valid req_ready req_data   | nine Q entries of one matrix
//  result  | rsp_valid rsp_ready rsp_data   | nine inverse entries, two flags
//  csr     | csr_we csr_addr csr_wdata      | symmetric mode, singular threshold
//
//  One transaction enters per cycle while the pipeline is not held; each of the
//  nine quotient lanes holds a DATA_W-stage restoring divider.
//  Reset is synchronous: clears pipeline valids, output and skid, and registers.
//  The output register has one skid entry behind it; the pipeline holds only
//  while that skid entry is full, so requests keep flowing while a result waits.
`timescale 1ns / 1ps
module matrix_inverse_3x3 import mi3_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int W     = DATA_W;
   localparam int CW    = 2 * W + 1;
   localparam int MAGW  = 3 * W;
   localparam int NPIPE = W + 9;

   logic                  csr_sym_ff;
   logic [THR_W-1:0]      csr_thr_ff;

   logic                  en;
   logic [NPIPE-1:0]      valid_ff;
   logic [NPIPE-1:0]      sym_ff;

   ent_type               e_in  [NUM_ENT];
   ent_type               e_ff  [NUM_ENT];
   ent_type               e1_ff [3];
   ent_type               e2_ff [3];

   logic signed [CW-1:0]  cof     [NUM_ENT];
   logic signed [CW-1:0]  cpipe_ff [4][NUM_ENT];
   logic signed [CW-1:0]  det_cv  [3];

   logic [MAGW-1:0]       dabs;
   logic                  dneg;
   logic                  sing;
   logic [MAGW-1:0]       dpipe_ff [W+1];
   logic [W+1:0][MAGW-1:0] dvec;
   logic                  sing_ff [W+2];

   ent_type               res [NUM_ENT];
   logic [NUM_ENT-1:0]    lane_sat;
   logic [NUM_ENT-1:0]    keep;
   ent_type               rv  [NUM_ENT];
   rsp_type               merged;
   logic                  new_v;

   logic                  out_valid_ff;
   rsp_type               out_data_ff;
   logic                  skid_valid_ff;
   rsp_type               skid_data_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_sym_ff <= 1'b0;
         csr_thr_ff <= THR_W'(1);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SYMMETRIC: csr_sym_ff <= csr_wdata[0];
            CSR_THRESHOLD: csr_thr_ff <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   assign en        = !skid_valid_ff;
   assign req_ready = en;

   // Mirror the upper triangle in symmetric mode
   always_comb begin
      e_in[IX_XX] = req_data.m_xx;
      e_in[IX_XY] = req_data.m_xy;
      e_in[IX_XZ] = req_data.m_xz;
      e_in[IX_YX] = csr_sym_ff ? req_data.m_xy : req_data.m_yx;
      e_in[IX_YY] = req_data.m_yy;
      e_in[IX_YZ] = req_data.m_yz;
      e_in[IX_ZX] = csr_sym_ff ? req_data.m_xz : req_data.m_zx;
      e_in[IX_ZY] = csr_sym_ff ? req_data.m_yz : req_data.m_zy;
      e_in[IX_ZZ] = req_data.m_zz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NPIPE-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sym_ff <= {sym_ff[NPIPE-2:0], csr_sym_ff};
         e_ff   <= e_in;
         e1_ff  <= e_ff[0:2];
         e2_ff  <= e1_ff;
      end
   end

   for (genvar i = 0; i < NUM_ENT; i++) begin : g_cof
      mi3_cof_lane u_cof (
         .clock (clock),
         .en    (en),
         .a     (e_ff[COF_A[i]]),
         .b     (e_ff[COF_B[i]]),
         .c     (e_ff[COF_C[i]]),
         .d     (e_ff[COF_D[i]]),
         .cof   (cof[i])
      );
   end

   // Carry the cofactors alongside the determinant stages
   always_ff @(posedge clock) begin
      if (en) begin
         cpipe_ff[0] <= cof;
         cpipe_ff[1] <= cpipe_ff[0];
         cpipe_ff[2] <= cpipe_ff[1];
         cpipe_ff[3] <= cpipe_ff[2];
      end
   end

   assign det_cv[0] = cof[IX_XX];
   assign det_cv[1] = cof[IX_YX];
   assign det_cv[2] = cof[IX_ZX];

   mi3_det #(.FRAC_BITS(FRAC_BITS)) u_det (
      .clock (clock),
      .en    (en),
      .ev    (e2_ff),
      .cv    (det_cv),
      .thr   (csr_thr_ff),
      .dabs  (dabs),
      .dneg  (dneg),
      .sing  (sing)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         dpipe_ff[0] <= dabs;
         sing_ff[0]  <= sing;
         for (int k = 1; k <= W; k++) begin
            dpipe_ff[k] <= dpipe_ff[k-1];
         end
         for (int k = 1; k < W + 2; k++) begin
            sing_ff[k] <= sing_ff[k-1];
         end
      end
   end

   assign dvec[0] = dabs;
   for (genvar j = 1; j <= W + 1; j++) begin : g_dvec
      assign dvec[j] = dpipe_ff[j-1];
   end

   for (genvar i = 0; i < NUM_ENT; i++) begin : g_div
      mi3_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock (clock),
         .en    (en),
         .cof   (cpipe_ff[3][i]),
         .dneg  (dneg),
         .dvec  (dvec),
         .res   (res[i]),
         .sat   (lane_sat[i])
      );
   end

   // Merge the lanes: zero on singular, drop the mirrored entries
   always_comb begin
      for (int i = 0; i < NUM_ENT; i++) begin
         keep[i] = !sing_ff[W+1] && !(sym_ff[NPIPE-1] && SYM_DROP[i]);
         rv[i]   = keep[i] ? res[i] : '0;
      end
      merged.r_xx      = rv[IX_XX];
      merged.r_xy      = rv[IX_XY];
      merged.r_xz      = rv[IX_XZ];
      merged.r_yx      = rv[IX_YX];
      merged.r_yy      = rv[IX_YY];
      merged.r_yz      = rv[IX_YZ];
      merged.r_zx      = rv[IX_ZX];
      merged.r_zy      = rv[IX_ZY];
      merged.r_zz      = rv[IX_ZZ];
      merged.singular  = sing_ff[W+1];
      merged.saturated = |(lane_sat & keep);
   end

   assign new_v = valid_ff[NPIPE-1] && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= new_v;
         end
      end else if (new_v) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_ready) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : merged;
      end else if (new_v) begin
         skid_data_ff <= merged;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef ASSERT_OFF
   a_singular_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.singular |->
         !rsp_data.saturated && rsp_data.r_xx == '0 && rsp_data.r_yy == '0 &&
         rsp_data.r_zz == '0)
      else $error("singular result carries nonzero data");

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff && !req_ready)
      else $error("skid entry held without a waiting result");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NPIPE-1] && en && out_valid_ff && !rsp_ready |=> skid_valid_ff)
      else $error("result dropped while output stalled");
`endif
endmodule
